// ===== hdl/imu_wmd_pkg.sv =====
// shared constants, types and codes of the imu window motion detector
package imu_wmd_pkg;

    // window and sample geometry
    localparam int WINDOW      = 100;
    localparam int SAMPLE_BITS = 16;
    localparam int AXES        = 6;
    localparam int GYRO_AXES   = 3;

    // derived widths
    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW + 1) + 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int PTR_W  = $clog2(WINDOW);
    localparam int DIV_W  = $clog2(WINDOW + 2);
    localparam int STEP_W = $clog2(SUM_W + 1);

    // configuration port
    localparam int THR_W      = 15;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam logic [THR_W-1:0]     THR_RESET     = THR_W'(1024);
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_THR  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_THR = CFG_IDX_W'(1);

    // queues between the parts
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic signed [SAMPLE_BITS-1:0] t_axis;
    typedef t_axis [AXES-1:0]              t_vec;
    typedef logic signed [SUM_W-1:0]       t_sum;
    typedef t_sum [AXES-1:0]               t_sum_vec;

    typedef struct packed {
        logic moving;
        logic window_full;
        t_vec mean;
    } t_result;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic done;
        t_vec quotient;
    } t_div_rsp;

endpackage

// ===== hdl/imu_wmd_front.sv =====
// front end: accepts sample requests into a short queue ahead of the engine
module imu_wmd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  imu_wmd_pkg::t_vec i_data,
    output logic              o_empty,
    input  logic              i_pop,
    output imu_wmd_pkg::t_vec o_data
);
    import imu_wmd_pkg::*;

    t_vec              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            end
            r_cnt <= r_cnt + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
    end

    // sample storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

endmodule

// ===== hdl/imu_wmd_out_q.sv =====
// result queue between the engine and the consumer
module imu_wmd_out_q (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  imu_wmd_pkg::t_result i_data,
    output logic                 o_empty,
    input  logic                 i_pop,
    output imu_wmd_pkg::t_result o_data
);
    import imu_wmd_pkg::*;

    t_result           r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            end
            r_cnt <= r_cnt + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

endmodule

// ===== hdl/imu_wmd_div.sv =====
// six-lane restoring divider, one quotient bit per lane per cycle, truncating toward zero
module imu_wmd_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  imu_wmd_pkg::t_div_req i_req,
    input  imu_wmd_pkg::t_sum_vec i_dividend,
    output imu_wmd_pkg::t_div_rsp o_rsp
);
    import imu_wmd_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_left;
    logic [DIV_W-1:0]  r_div;
    logic [AXES-1:0]   r_neg;
    logic [SUM_W-1:0]  r_quo [AXES];
    logic [DIV_W-1:0]  r_rem [AXES];
    t_vec              r_mean;

    logic [DIV_W:0]    trial [AXES];
    logic [DIV_W+1:0]  diff  [AXES];
    logic [AXES-1:0]   ge;
    logic [DIV_W-1:0]  n_rem [AXES];

    // one restoring step per lane
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            trial[a] = {r_rem[a], r_quo[a][SUM_W-1]};
            diff[a]  = {1'b0, trial[a]} - {2'b00, r_div};
            ge[a]    = !diff[a][DIV_W+1];
            n_rem[a] = ge[a] ? diff[a][DIV_W-1:0] : trial[a][DIV_W-1:0];
        end
    end

    // step sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_left <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_left <= STEP_W'(SUM_W);
            end else if (r_busy) begin
                if (r_left != '0) begin
                    r_left <= r_left - STEP_W'(1);
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand, partial remainder and signed quotient
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_div <= i_req.divisor;
            for (int a = 0; a < AXES; a++) begin
                r_neg[a] <= i_dividend[a][SUM_W-1];
                r_quo[a] <= i_dividend[a][SUM_W-1] ? (~i_dividend[a] + 1'b1) : i_dividend[a];
                r_rem[a] <= '0;
            end
        end else if (r_busy && r_left != '0) begin
            for (int a = 0; a < AXES; a++) begin
                r_quo[a] <= {r_quo[a][SUM_W-2:0], ge[a]};
                r_rem[a] <= n_rem[a];
            end
        end else if (r_busy) begin
            for (int a = 0; a < AXES; a++) begin
                r_mean[a] <= r_neg[a] ? t_axis'(~r_quo[a][SAMPLE_BITS-1:0] + 1'b1)
                                      : t_axis'(r_quo[a][SAMPLE_BITS-1:0]);
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_mean;

endmodule

// ===== hdl/imu_wmd_back.sv =====
// back end: history memory, running sums, mean division and deviation check
module imu_wmd_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [imu_wmd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [imu_wmd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_in_empty,
    input  imu_wmd_pkg::t_vec                i_in_data,
    output logic                             o_in_pop,
    input  logic                             i_out_full,
    output logic                             o_out_push,
    output imu_wmd_pkg::t_result             o_out_data
);
    import imu_wmd_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LAUNCH = 2'd1;
    localparam logic [1:0] ST_WAIT   = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    localparam int CMP_W = (SAMPLE_BITS + 1 > THR_W) ? SAMPLE_BITS + 1 : THR_W;

    logic [1:0]       r_state;
    logic [THR_W-1:0] r_gyro_thr;
    logic [THR_W-1:0] r_accel_thr;
    logic [CNT_W-1:0] r_held;
    logic [PTR_W-1:0] r_ptr;
    logic             r_full;
    t_sum_vec         r_sum;
    t_vec             r_samp;
    t_vec             r_old;
    t_vec             mem [WINDOW];

    logic             accept;
    t_div_req         div_req;
    t_div_rsp         div_rsp;
    logic [SAMPLE_BITS:0] dev   [AXES];
    logic [SAMPLE_BITS:0] dev_abs [AXES];
    logic [THR_W-1:0] thr   [AXES];
    logic [AXES-1:0]  over;

    assign accept   = (r_state == ST_IDLE) && !i_in_empty && !i_out_full;
    assign o_in_pop = accept;

    // divider request: divisor is the number of samples held including the new one
    assign div_req.start   = (r_state == ST_LAUNCH);
    assign div_req.divisor = DIV_W'(r_held) + DIV_W'(1);

    imu_wmd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (r_sum),
        .o_rsp      (div_rsp)
    );

    // deviation of the newest sample from each mean
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            thr[a]     = (a < GYRO_AXES) ? r_gyro_thr : r_accel_thr;
            dev[a]     = {r_samp[a][SAMPLE_BITS-1], r_samp[a]}
                       - {div_rsp.quotient[a][SAMPLE_BITS-1], div_rsp.quotient[a]};
            dev_abs[a] = dev[a][SAMPLE_BITS] ? (~dev[a] + 1'b1) : dev[a];
            over[a]    = CMP_W'(dev_abs[a]) > CMP_W'(thr[a]);
        end
    end

    assign o_out_push             = (r_state == ST_DONE);
    assign o_out_data.moving      = r_full && (|over);
    assign o_out_data.window_full = r_full;
    assign o_out_data.mean        = div_rsp.quotient;

    // threshold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_thr  <= THR_RESET;
            r_accel_thr <= THR_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GYRO_THR:  r_gyro_thr  <= i_cfg_data[THR_W-1:0];
                CFG_ACCEL_THR: r_accel_thr <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer, window bookkeeping and running sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_held  <= '0;
            r_ptr   <= '0;
            r_full  <= 1'b0;
            r_sum   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_LAUNCH;
                        r_full  <= (r_held == CNT_W'(WINDOW));
                        for (int a = 0; a < AXES; a++) begin
                            r_sum[a] <= r_sum[a]
                                      + {{(SUM_W - SAMPLE_BITS){i_in_data[a][SAMPLE_BITS-1]}},
                                         i_in_data[a]};
                        end
                    end
                end
                ST_LAUNCH: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (div_rsp.done) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    r_state <= ST_IDLE;
                    r_ptr   <= (r_ptr == PTR_W'(WINDOW - 1)) ? '0 : r_ptr + PTR_W'(1);
                    if (r_full) begin
                        // evict the oldest sample
                        for (int a = 0; a < AXES; a++) begin
                            r_sum[a] <= r_sum[a]
                                      - {{(SUM_W - SAMPLE_BITS){r_old[a][SAMPLE_BITS-1]}},
                                         r_old[a]};
                        end
                    end else begin
                        r_held <= r_held + CNT_W'(1);
                    end
                end
            endcase
        end
    end

    // sample history: read the slot to be replaced, write the new sample there
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_samp <= i_in_data;
            r_old  <= mem[r_ptr];
        end
        if (r_state == ST_DONE) begin
            mem[r_ptr] <= r_samp;
        end
    end

endmodule

// ===== hdl/imu_window_motion_detector_core.sv =====
// imu window motion detector: one result per six-axis sample. Each sample passes through
// pop, divider launch, SUM_W divide steps, sign fix, done state and result write; the
// next sample is taken only once that result is written and the result queue has room,
// as the six-lane bit-serial divider serves one sample at a time. Synchronous active-low
// reset clears the queues, running sums, fill count and pointer, and loads both thresholds
// with 1024; the history memory is not cleared, as slots are used only once written.
module imu_window_motion_detector_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [imu_wmd_pkg::SAMPLE_BITS-1:0] i_gyro_x,
    input  logic signed [imu_wmd_pkg::SAMPLE_BITS-1:0] i_gyro_y,
    input  logic signed [imu_wmd_pkg::SAMPLE_BITS-1:0] i_gyro_z,
    input  logic signed [imu_wmd_pkg::SAMPLE_BITS-1:0] i_accel_x,
    input  logic signed [imu_wmd_pkg::SAMPLE_BITS-1:0] i_accel_y,
    input  logic signed [imu_wmd_pkg::SAMPLE_BITS-1:0] i_accel_z,
    output logic                                empty,
    input  logic                                pop,
    output logic                                o_moving,
    output logic                                o_window_full,
    output logic signed [imu_wmd_pkg::SAMPLE_BITS-1:0] o_mean_gyro_x,
    output logic signed [imu_wmd_pkg::SAMPLE_BITS-1:0] o_mean_gyro_y,
    output logic signed [imu_wmd_pkg::SAMPLE_BITS-1:0] o_mean_gyro_z,
    output logic signed [imu_wmd_pkg::SAMPLE_BITS-1:0] o_mean_accel_x,
    output logic signed [imu_wmd_pkg::SAMPLE_BITS-1:0] o_mean_accel_y,
    output logic signed [imu_wmd_pkg::SAMPLE_BITS-1:0] o_mean_accel_z,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [imu_wmd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [imu_wmd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import imu_wmd_pkg::*;

    t_vec    in_vec;
    t_vec    q_data;
    logic    q_empty;
    logic    q_pop;
    logic    res_full;
    logic    res_push;
    t_result res_data;
    t_result out_data;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    // sample request packing
    assign in_vec[0] = i_gyro_x;
    assign in_vec[1] = i_gyro_y;
    assign in_vec[2] = i_gyro_z;
    assign in_vec[3] = i_accel_x;
    assign in_vec[4] = i_accel_y;
    assign in_vec[5] = i_accel_z;

    imu_wmd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_data  (in_vec),
        .o_empty (q_empty),
        .i_pop   (q_pop),
        .o_data  (q_data)
    );

    imu_wmd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_empty  (q_empty),
        .i_in_data   (q_data),
        .o_in_pop    (q_pop),
        .i_out_full  (res_full),
        .o_out_push  (res_push),
        .o_out_data  (res_data)
    );

    imu_wmd_out_q u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .o_full  (res_full),
        .i_data  (res_data),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (out_data)
    );

    // result unpacking
    assign o_moving       = out_data.moving;
    assign o_window_full  = out_data.window_full;
    assign o_mean_gyro_x  = out_data.mean[0];
    assign o_mean_gyro_y  = out_data.mean[1];
    assign o_mean_gyro_z  = out_data.mean[2];
    assign o_mean_accel_x = out_data.mean[3];
    assign o_mean_accel_y = out_data.mean[4];
    assign o_mean_accel_z = out_data.mean[5];

endmodule

// ===== hdl/imu_wmd_checker.sv =====
// port-level checker for the imu window motion detector, bound to the top level
module imu_wmd_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    input  logic                                full,
    input  logic                                empty,
    input  logic                                pop,
    input  logic                                o_moving,
    input  logic                                o_window_full,
    input  logic signed [imu_wmd_pkg::SAMPLE_BITS-1:0] o_mean_gyro_x,
    input  logic signed [imu_wmd_pkg::SAMPLE_BITS-1:0] o_mean_gyro_y,
    input  logic signed [imu_wmd_pkg::SAMPLE_BITS-1:0] o_mean_gyro_z,
    input  logic signed [imu_wmd_pkg::SAMPLE_BITS-1:0] o_mean_accel_x,
    input  logic signed [imu_wmd_pkg::SAMPLE_BITS-1:0] o_mean_accel_y,
    input  logic signed [imu_wmd_pkg::SAMPLE_BITS-1:0] o_mean_accel_z
);
    import imu_wmd_pkg::*;

    // two queues plus the one request inside the engine
    localparam int MAX_INFLIGHT = 2 * QDEPTH + 1;
    localparam int FL_W         = $clog2(MAX_INFLIGHT + 2);

    logic [FL_W-1:0] r_inflight;
    logic            req_in;
    logic            req_out;

    assign req_in  = push && !full;
    assign req_out = pop && !empty;

    // requests taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + FL_W'(req_in) - FL_W'(req_out);
        end
    end

    // queues come out of reset empty
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (empty && !full))
        else $error("queues not empty after reset");

    // a result only exists for a request that was taken
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (r_inflight != '0))
        else $error("result shown with no request outstanding");

    // storage bounds the number of outstanding requests
    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= FL_W'(MAX_INFLIGHT))
        else $error("more requests outstanding than the block can hold");

    // motion is only flagged once the window has filled
    a_moving_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_moving) |-> o_window_full)
        else $error("moving flagged before window full");

    // a waiting result holds until taken
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_moving) && $stable(o_window_full)
                              && $stable(o_mean_gyro_x) && $stable(o_mean_gyro_y)
                              && $stable(o_mean_gyro_z) && $stable(o_mean_accel_x)
                              && $stable(o_mean_accel_y) && $stable(o_mean_accel_z)))
        else $error("waiting result changed before it was taken");

endmodule

bind imu_window_motion_detector_core imu_wmd_checker u_checker (.*);

// ===== bench/imu_window_motion_detector_core_tb.sv =====
// testbench of the imu window motion detector core: directed samples, then random windows
module imu_window_motion_detector_core_tb;
    import imu_wmd_pkg::*;

    localparam int GAP_MAX     = 13;
    localparam int SETTLE      = 40;
    localparam int STALL_LIMIT = 3000;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 220;
    localparam int DIR_ROWS    = 14;
    localparam int REPORT_MAX  = 10;
    localparam int AXIS_MAX    = 2 ** (SAMPLE_BITS - 1) - 1;
    localparam int AXIS_MIN    = -(2 ** (SAMPLE_BITS - 1));

    // directed sample with an optional hand-worked mean (these rows never fill the window)
    typedef struct {
        int smp [AXES];
        bit typed;
        int mean [AXES];
    } t_sample_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    logic                  empty;
    logic                  pop;
    t_axis                 i_gyro_x, i_gyro_y, i_gyro_z;
    t_axis                 i_accel_x, i_accel_y, i_accel_z;
    logic                  o_moving;
    logic                  o_window_full;
    t_axis                 o_mean_gyro_x, o_mean_gyro_y, o_mean_gyro_z;
    t_axis                 o_mean_accel_x, o_mean_accel_y, o_mean_accel_z;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // hand-worked expectation travelling alongside a directed request
    logic                  row_typed;
    t_vec                  row_mean;

    // own copy of the window, sums and thresholds
    t_vec                  window_store [WINDOW];
    longint                axis_total [AXES];
    int                    fill_count;
    int                    oldest_slot;
    logic [THR_W-1:0]      gyro_limit;
    logic [THR_W-1:0]      accel_limit;
    t_result               stats_due [$];

    int  mismatches      = 0;
    int  results_checked = 0;
    int  moving_seen     = 0;
    int  full_seen       = 0;
    int  items_sent      = 0;
    int  cfg_writes      = 0;
    int  quiet_cycles    = 0;
    bit  quick_send      = 1'b0;
    bit  quick_take      = 1'b0;

    string axis_name [AXES] = '{"gyro_x", "gyro_y", "gyro_z", "accel_x", "accel_y", "accel_z"};

    t_sample_row opening_samples [DIR_ROWS] = '{
        '{'{AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN}, 1'b1,
          '{AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN}},
        // sum -1 over two samples truncates to zero
        '{'{AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX}, 1'b1,
          '{0, 0, 0, 0, 0, 0}},
        '{'{0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 0, 0}},
        '{'{1, -1, 2, -2, 3, -3}, 1'b0, '{default: 0}},
        '{'{21845, -21846, 21845, -21846, 21845, -21846}, 1'b0, '{default: 0}},
        '{'{-21846, 21845, -21846, 21845, -21846, 21845}, 1'b0, '{default: 0}},
        '{'{AXIS_MAX, AXIS_MIN, 0, -1, 1, 16384}, 1'b0, '{default: 0}},
        '{'{-1, -1, -1, -1, -1, -1}, 1'b0, '{default: 0}},
        '{'{AXIS_MIN, AXIS_MAX, AXIS_MIN, AXIS_MAX, AXIS_MIN, AXIS_MAX}, 1'b0, '{default: 0}},
        '{'{1024, -1024, 1025, -1025, 1023, -1023}, 1'b0, '{default: 0}},
        '{'{0, 0, 0, 0, 0, 0}, 1'b0, '{default: 0}},
        '{'{-7, 7, -13, 13, -100, 100}, 1'b0, '{default: 0}},
        '{'{12345, -12345, 30000, -30000, 256, -256}, 1'b0, '{default: 0}},
        '{'{AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MIN, AXIS_MIN, AXIS_MIN}, 1'b0, '{default: 0}}
    };

    imu_window_motion_detector_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_gyro_x       (i_gyro_x),
        .i_gyro_y       (i_gyro_y),
        .i_gyro_z       (i_gyro_z),
        .i_accel_x      (i_accel_x),
        .i_accel_y      (i_accel_y),
        .i_accel_z      (i_accel_z),
        .empty          (empty),
        .pop            (pop),
        .o_moving       (o_moving),
        .o_window_full  (o_window_full),
        .o_mean_gyro_x  (o_mean_gyro_x),
        .o_mean_gyro_y  (o_mean_gyro_y),
        .o_mean_gyro_z  (o_mean_gyro_z),
        .o_mean_accel_x (o_mean_accel_x),
        .o_mean_accel_y (o_mean_accel_y),
        .o_mean_accel_z (o_mean_accel_z),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // window means and motion flag for one sample, advancing the window
    function automatic t_result predict_window_stats(input t_vec smp);
        t_result r;
        int      count;
        int      a;
        longint  q;
        longint  d;
        longint  lim;
        count         = fill_count + 1;
        r.moving      = 1'b0;
        r.window_full = (count > WINDOW);
        for (a = 0; a < AXES; a++) begin
            axis_total[a] += longint'(smp[a]);
            q = axis_total[a] / count;
            r.mean[a] = t_axis'(q);
            if (r.window_full) begin
                d = longint'(smp[a]) - q;
                if (d < 0) begin
                    d = -d;
                end
                lim = (a < GYRO_AXES) ? longint'(gyro_limit) : longint'(accel_limit);
                if (d > lim) begin
                    r.moving = 1'b1;
                end
                // evict the oldest sample after the means are formed
                axis_total[a] -= longint'(window_store[oldest_slot][a]);
            end
        end
        if (r.window_full) begin
            window_store[oldest_slot] = smp;
            oldest_slot = (oldest_slot + 1) % WINDOW;
        end else begin
            window_store[(oldest_slot + fill_count) % WINDOW] = smp;
            fill_count = count;
        end
        return r;
    endfunction

    task automatic note_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
        end
    endtask

    // one sample request after a random gap
    task automatic send_sample(input t_vec smp, input logic typed, input t_vec mean_typed);
        int gap;
        gap = quick_send ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_gyro_x  <= smp[0];
        i_gyro_y  <= smp[1];
        i_gyro_z  <= smp[2];
        i_accel_x <= smp[3];
        i_accel_y <= smp[4];
        i_accel_z <= smp[5];
        row_typed <= typed;
        row_mean  <= mean_typed;
        do @(posedge i_clk); while (full);
        items_sent++;
    endtask

    // stop sending until every expected result has been taken, then let the core settle
    task automatic drain_results();
        push <= 1'b0;
        do @(posedge i_clk); while (stats_due.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // valid stays high for back-to-back writes; the caller lowers it after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // predict on accepted samples, check accepted results, follow register writes
    always @(posedge i_clk) begin
        t_vec    smp;
        t_result want;
        t_result got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_GYRO_THR) begin
                    gyro_limit = i_cfg_data[THR_W-1:0];
                end else if (i_cfg_index == CFG_ACCEL_THR) begin
                    accel_limit = i_cfg_data[THR_W-1:0];
                end
                cfg_writes++;
            end
            if (push && !full) begin
                smp[0] = i_gyro_x;
                smp[1] = i_gyro_y;
                smp[2] = i_gyro_z;
                smp[3] = i_accel_x;
                smp[4] = i_accel_y;
                smp[5] = i_accel_z;
                want = predict_window_stats(smp);
                if (row_typed) begin
                    want.moving      = 1'b0;
                    want.window_full = 1'b0;
                    want.mean        = row_mean;
                end
                stats_due = {stats_due, want};
            end
            if (pop && !empty) begin
                got.moving      = o_moving;
                got.window_full = o_window_full;
                got.mean[0]     = o_mean_gyro_x;
                got.mean[1]     = o_mean_gyro_y;
                got.mean[2]     = o_mean_gyro_z;
                got.mean[3]     = o_mean_accel_x;
                got.mean[4]     = o_mean_accel_y;
                got.mean[5]     = o_mean_accel_z;
                results_checked++;
                if (got.moving === 1'b1) moving_seen++;
                if (got.window_full === 1'b1) full_seen++;
                if (stats_due.size() == 0) begin
                    note_mismatch("results pending at pop", 1, 0);
                end else begin
                    want = stats_due.pop_front();
                    if (got.moving !== want.moving) begin
                        note_mismatch("moving", want.moving, got.moving);
                    end
                    if (got.window_full !== want.window_full) begin
                        note_mismatch("window_full", want.window_full, got.window_full);
                    end
                    for (int a = 0; a < AXES; a++) begin
                        if (got.mean[a] !== want.mean[a]) begin
                            note_mismatch({"mean_", axis_name[a]}, want.mean[a], got.mean[a]);
                        end
                    end
                end
            end
        end
    end

    // result side: random stalls with occasional stretches of none
    initial begin : take_results
        int stall;
        pop <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if ($urandom_range(0, 29) == 0) begin
                quick_take = !quick_take;
            end
            stall = quick_take ? 0 : $urandom_range(0, GAP_MAX);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    // watchdog on cycles where no request of any kind moves
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        do @(posedge i_clk); while (quiet_cycles < STALL_LIMIT);
        $display("watchdog: nothing accepted for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // stimulus
    initial begin : drive_samples
        t_vec smp;
        t_vec hand_mean;
        int   base [AXES];
        int   phase;
        int   sent;
        int   kind;
        int   seg_len;
        int   amp;
        int   k;
        int   a;
        int   v;
        push        <= 1'b0;
        i_gyro_x    <= '0;
        i_gyro_y    <= '0;
        i_gyro_z    <= '0;
        i_accel_x   <= '0;
        i_accel_y   <= '0;
        i_accel_z   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        row_typed   <= 1'b0;
        row_mean    <= '0;
        i_rst_n     <= 1'b0;
        for (a = 0; a < AXES; a++) begin
            axis_total[a] = 0;
        end
        fill_count  = 0;
        oldest_slot = 0;
        gyro_limit  = THR_RESET;
        accel_limit = THR_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, sign patterns and truncation toward zero
        for (int r = 0; r < DIR_ROWS; r++) begin
            for (a = 0; a < AXES; a++) begin
                smp[a]       = t_axis'(opening_samples[r].smp[a]);
                hand_mean[a] = t_axis'(opening_samples[r].mean[a]);
            end
            send_sample(smp, opening_samples[r].typed, hand_mean);
        end

        // random windows, one threshold setting per phase
        for (phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                drain_results();
                case (phase)
                    1: begin
                        write_reg(CFG_GYRO_THR, '0);
                        write_reg(CFG_ACCEL_THR, '0);
                    end
                    2: begin
                        // top bit of the data is dropped, leaving the largest threshold
                        write_reg(CFG_GYRO_THR, '1);
                        write_reg(CFG_ACCEL_THR, CFG_DATA_W'(AXIS_MAX));
                    end
                    3: begin
                        write_reg(CFG_GYRO_THR, CFG_DATA_W'($urandom));
                        write_reg(CFG_ACCEL_THR, CFG_DATA_W'($urandom));
                        // unmapped index must leave both thresholds alone
                        write_reg(CFG_IDX_W'($urandom_range(int'(CFG_ACCEL_THR) + 1,
                                                            (1 << CFG_IDX_W) - 1)),
                                  CFG_DATA_W'($urandom));
                    end
                    default: begin
                        write_reg(CFG_GYRO_THR, CFG_DATA_W'($urandom_range(0, 2047)));
                        write_reg(CFG_ACCEL_THR,
                                  CFG_DATA_W'($urandom_range(0, 2047) | ($urandom_range(0, 1) << 15)));
                    end
                endcase
                i_cfg_valid <= 1'b0;
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                // segment: mostly quiet sensor with noise and spikes, some pure noise, some rails
                kind       = $urandom_range(0, 99);
                seg_len    = $urandom_range(20, 150);
                quick_send = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 4))
                    0: amp = 0;
                    1: amp = 16;
                    2: amp = 300;
                    3: amp = 2000;
                    default: amp = 9000;
                endcase
                for (a = 0; a < AXES; a++) begin
                    if (kind >= 15 && kind < 25) begin
                        base[a] = $urandom_range(0, 1) ? AXIS_MAX : AXIS_MIN;
                    end else begin
                        base[a] = int'($urandom_range(0, 65535)) + AXIS_MIN;
                    end
                end
                for (k = 0; k < seg_len && sent < PHASE_ITEMS; k++) begin
                    for (a = 0; a < AXES; a++) begin
                        if (kind < 15) begin
                            smp[a] = t_axis'($urandom);
                        end else if (kind < 25) begin
                            smp[a] = t_axis'(base[a]);
                        end else begin
                            v = base[a] + int'($urandom_range(0, 2 * amp)) - amp;
                            if ($urandom_range(0, 24) == 0) begin
                                v += int'($urandom_range(0, 65535)) + AXIS_MIN;
                            end
                            if (v > AXIS_MAX) v = AXIS_MAX;
                            if (v < AXIS_MIN) v = AXIS_MIN;
                            smp[a] = t_axis'(v);
                        end
                    end
                    send_sample(smp, 1'b0, smp);
                    sent++;
                    // in the first phase, hold off midway until the core has handed back everything
                    if (phase == 0 && sent == PHASE_ITEMS / 2) begin
                        drain_results();
                    end
                end
            end
        end
        drain_results();

        $display("sent %0d samples across %0d threshold settings, %0d register writes",
                 items_sent, PHASES, cfg_writes);
        $display("checked %0d results, %0d flagged moving, %0d with the window full",
                 results_checked, moving_seen, full_seen);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
